FILE: sv/rms_normalization_row_top_defines.svh
// assertion macros for the rms normalization row block
`ifndef RMS_NORMALIZATION_ROW_TOP_DEFINES_SVH
`define RMS_NORMALIZATION_ROW_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RMSN_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RMSN_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMSN_ASSERT(lbl, clk, rst, prop, msg)
`define RMSN_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: sv/rmsn_pkg.sv
// shared types and constants of the rms normalization row block
`default_nettype none
package rmsn_pkg;
   localparam int DATA_WIDTH  = 16;
   localparam int ROW_MAX_DEF = 64;
   localparam int COUNT_WIDTH = 7;
   localparam int SUM_WIDTH   = 37;
   localparam int EPS_WIDTH   = 24;
   localparam int R_WIDTH     = 32;
   localparam int E_WIDTH     = 4;
   localparam logic [EPS_WIDTH-1:0] EPS_RESET = 24'd168;
   localparam logic [0:0] REG_EPSILON = 1'b0;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] x_value;
      logic signed [DATA_WIDTH-1:0] scale_value;
      logic                         last_element;
   } rmsn_req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] y_value;
      logic                         last_output;
      logic                         saturated;
      logic                         row_overflow;
   } rmsn_rsp_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] x;
      logic signed [DATA_WIDTH-1:0] s;
   } rmsn_entry_type;

   typedef struct packed {
      logic                   done;
      logic [R_WIDTH-1:0]     r;
      logic [E_WIDTH-1:0]     e;
   } rmsn_root_type;

   typedef struct packed {
      logic                   start;
      logic [COUNT_WIDTH-1:0] count;
      logic                   overflow;
   } rmsn_emit_ctl_type;

   typedef enum logic [1:0] {S_ACC, S_LAUNCH, S_RECIP, S_EMIT} rmsn_top_state_type;
   typedef enum logic [2:0] {R_IDLE, R_DIV, R_SUM, R_NORM, R_ROOT} rmsn_root_state_type;
endpackage
`default_nettype wire

FILE: sv/rmsn_store.sv
// row and scale memory, one write and one registered read port
`default_nettype none
module rmsn_store #(
   parameter int ROW_MAX = rmsn_pkg::ROW_MAX_DEF,
   parameter int AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  wire rmsn_pkg::rmsn_entry_type wr_data,
   input  wire logic                     rd_en,
   input  wire logic [AW-1:0]            rd_addr,
   output rmsn_pkg::rmsn_entry_type      rd_data
);
   import rmsn_pkg::*;
   rmsn_entry_type mem_ff [ROW_MAX];
   rmsn_entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_ff;
endmodule
`default_nettype wire

FILE: sv/rmsn_recip.sv
// mean square divider, normalizer and bit-serial reciprocal square root
`default_nettype none
module rmsn_recip (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [rmsn_pkg::SUM_WIDTH-1:0]      sum,
   input  wire logic [rmsn_pkg::COUNT_WIDTH-1:0]    count,
   input  wire logic [rmsn_pkg::EPS_WIDTH-1:0]      eps,
   output rmsn_pkg::rmsn_root_type                  root
);
   import rmsn_pkg::*;
   localparam logic [96:0] LIMIT = 97'(1) << 94;

   rmsn_root_state_type state_ff, state_in;
   logic done_ff, done_in;
   logic [5:0] step_ff;
   logic [SUM_WIDTH-1:0] quo_ff;
   logic [COUNT_WIDTH-1:0] rem_ff, div_ff, rem_nx;
   logic [EPS_WIDTH-1:0] eps_ff;
   logic [31:0] mn_ff, m_sat;
   logic [E_WIDTH-1:0] e_ff;
   logic [R_WIDTH-1:0] r_ff;
   logic [63:0] u_ff, uc;
   logic [96:0] t_ff, tc;
   logic [COUNT_WIDTH:0] trial;
   logic ge, fits, mn_small;
   logic [4:0] b;
   logic [SUM_WIDTH:0] m_sum;

   assign b = step_ff[4:0];
   assign trial = {rem_ff, quo_ff[SUM_WIDTH-1]};
   assign ge = trial >= {1'b0, div_ff};
   assign rem_nx = ge ? COUNT_WIDTH'(trial - {1'b0, div_ff}) : COUNT_WIDTH'(trial);
   assign m_sum = {1'b0, quo_ff} + (SUM_WIDTH+1)'(eps_ff);
   assign m_sat = (m_sum[SUM_WIDTH:32] != '0) ? 32'hFFFF_FFFF : m_sum[31:0];
   assign mn_small = mn_ff < 32'h4000_0000;
   assign uc = u_ff + (64'(mn_ff) << b);
   assign tc = t_ff + (97'(u_ff) << (6'(b) + 6'd1)) + (97'(mn_ff) << {b, 1'b0});
   assign fits = tc <= LIMIT;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         R_IDLE: if (start) state_in = R_DIV;
         R_DIV:  if (step_ff == 6'd0) state_in = R_SUM;
         R_SUM:  state_in = R_NORM;
         R_NORM: begin
            if (mn_ff == 32'd0) begin
               state_in = R_IDLE;
               done_in  = 1'b1;
            end else if (!mn_small) begin
               state_in = R_ROOT;
            end
         end
         R_ROOT: begin
            if (step_ff == 6'd0) begin
               state_in = R_IDLE;
               done_in  = 1'b1;
            end
         end
         default: state_in = R_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         R_IDLE: begin
            if (start) begin
               quo_ff  <= sum;
               rem_ff  <= '0;
               div_ff  <= count;
               eps_ff  <= eps;
               step_ff <= 6'(SUM_WIDTH - 1);
            end
         end
         R_DIV: begin
            quo_ff  <= {quo_ff[SUM_WIDTH-2:0], ge};
            rem_ff  <= rem_nx;
            step_ff <= step_ff - 6'd1;
         end
         R_SUM: begin
            mn_ff <= m_sat;
            e_ff  <= '0;
         end
         R_NORM: begin
            if (mn_ff != 32'd0 && mn_small) begin
               mn_ff <= {mn_ff[29:0], 2'b00};
               e_ff  <= e_ff + E_WIDTH'(1);
            end else begin
               r_ff    <= '0;
               u_ff    <= '0;
               t_ff    <= '0;
               step_ff <= 6'(R_WIDTH - 1);
            end
         end
         R_ROOT: begin
            if (fits) begin
               r_ff <= r_ff | (R_WIDTH'(1) << b);
               u_ff <= uc;
               t_ff <= tc;
            end
            step_ff <= step_ff - 6'd1;
         end
         default: ;
      endcase
   end

   assign root.done = done_ff;
   assign root.r    = r_ff;
   assign root.e    = e_ff;
endmodule
`default_nettype wire

FILE: sv/rmsn_emit.sv
// row replay and scaling pipeline that produces the result beats
`default_nettype none
module rmsn_emit #(
   parameter int ROW_MAX = rmsn_pkg::ROW_MAX_DEF,
   parameter int AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rmsn_pkg::rmsn_emit_ctl_type ctl,
   input  wire rmsn_pkg::rmsn_root_type     root,
   output logic                             rd_en,
   output logic [AW-1:0]                    rd_addr,
   input  wire rmsn_pkg::rmsn_entry_type    rd_data,
   output logic                             rsp_valid,
   output rmsn_pkg::rmsn_rsp_type           rsp_data
);
   import rmsn_pkg::*;
   localparam logic [DATA_WIDTH-1:0] POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] NEG_MAX = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic issue_ff, v1_ff, v2_ff, v3_ff, out_v_ff;
   logic last1_ff, last2_ff, last3_ff, neg2_ff, neg3_ff;
   logic [COUNT_WIDTH-1:0] k_ff;
   logic [2*DATA_WIDTH-1:0] p2_ff;
   logic [63:0] pr3_ff, rnd, mag;
   logic [DATA_WIDTH-1:0] ax, as;
   logic [5:0] sh;
   logic last_k;
   rmsn_rsp_type out_ff, out_in;

   assign last_k  = k_ff == ctl.count - COUNT_WIDTH'(1);
   assign rd_en   = issue_ff;
   assign rd_addr = k_ff[AW-1:0];
   assign ax = rd_data.x[DATA_WIDTH-1] ? DATA_WIDTH'(-rd_data.x) : rd_data.x;
   assign as = rd_data.s[DATA_WIDTH-1] ? DATA_WIDTH'(-rd_data.s) : rd_data.s;
   assign sh  = 6'd47 - 6'(root.e);
   assign rnd = pr3_ff + (64'(1) << (sh - 6'd1));
   assign mag = rnd >> sh;

   always_comb begin
      out_in.last_output  = last3_ff;
      out_in.row_overflow = ctl.overflow;
      out_in.saturated    = 1'b0;
      if (mag == 64'd0) begin
         out_in.y_value = '0;
      end else if (neg3_ff) begin
         if (mag > 64'(NEG_MAX)) begin
            out_in.y_value   = NEG_MAX;
            out_in.saturated = 1'b1;
         end else begin
            out_in.y_value = DATA_WIDTH'(-mag);
         end
      end else begin
         if (mag > 64'(POS_MAX)) begin
            out_in.y_value   = POS_MAX;
            out_in.saturated = 1'b1;
         end else begin
            out_in.y_value = DATA_WIDTH'(mag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
         k_ff     <= '0;
      end else begin
         if (ctl.start) begin
            issue_ff <= 1'b1;
            k_ff     <= '0;
         end else if (issue_ff) begin
            k_ff <= k_ff + COUNT_WIDTH'(1);
            if (last_k) issue_ff <= 1'b0;
         end
         v1_ff    <= issue_ff;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         out_v_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      last1_ff <= last_k;
      last2_ff <= last1_ff;
      neg2_ff  <= rd_data.x[DATA_WIDTH-1] ^ rd_data.s[DATA_WIDTH-1];
      p2_ff    <= ax * as;
      last3_ff <= last2_ff;
      neg3_ff  <= neg2_ff;
      pr3_ff   <= 64'(p2_ff) * 64'(root.r);
      out_ff   <= out_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
endmodule
`default_nettype wire

FILE: sv/rms_normalization_row_top.sv
// top level of the rms normalization row block
// usage:
//  - elements enter as req_data beats when start is high and busy is low,
//    one per cycle while the row is being gathered
//  - the beat with last_element set closes the row; busy then rises and
//    stays high until the final result beat of the row has left
//  - after the last element, the mean square divider runs (one quotient
//    bit a cycle), then normalizing, then the reciprocal square root (one
//    bit a cycle), then one result beat per cycle leaves through a memory
//    and multiplier pipeline
//  - results appear on rsp_data for one cycle with rsp_valid; the receiver
//    cannot stall and must take every beat
//  - elements past ROW_MAX are dropped and row_overflow marks the row
//  - epsilon_q sits at byte address 0 of the apb port; the user must see that it is written only when idle
//  - synchronous reset returns to gathering with an empty row and
//    epsilon_q at its reset value; the row memory is not cleared
`default_nettype none
`include "rms_normalization_row_top_defines.svh"
module rms_normalization_row_top #(
   parameter int ROW_MAX = rmsn_pkg::ROW_MAX_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire rmsn_pkg::rmsn_req_type req_data,
   output logic                        rsp_valid,
   output rmsn_pkg::rmsn_rsp_type      rsp_data,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [2:0]             paddr,
   input  wire logic [31:0]            pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import rmsn_pkg::*;
   localparam int AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;

   rmsn_top_state_type state_ff, state_in;
   logic [SUM_WIDTH-1:0] sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic ovf_ff, ovf_in;
   logic [EPS_WIDTH-1:0] eps_ff;
   logic accept, room, wr_en, rd_en, row_done, recip_start, emit_start;
   logic [DATA_WIDTH-1:0] ax;
   logic [AW-1:0] rd_addr;
   rmsn_entry_type wr_data, rd_data;
   rmsn_root_type root;
   rmsn_emit_ctl_type ectl;

   assign busy     = state_ff != S_ACC;
   assign accept   = start && !busy;
   assign room     = count_ff < COUNT_WIDTH'(ROW_MAX);
   assign wr_en    = accept && room;
   assign wr_data  = '{x: req_data.x_value, s: req_data.scale_value};
   assign ax = req_data.x_value[DATA_WIDTH-1] ? DATA_WIDTH'(-req_data.x_value)
                                              : req_data.x_value;
   assign row_done = rsp_valid && rsp_data.last_output;
   assign pready   = 1'b1;
   assign prdata   = (paddr[2] == REG_EPSILON) ? 32'(eps_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (psel && penable && pwrite && paddr[2] == REG_EPSILON) begin
         eps_ff <= pwdata[EPS_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ACC;
         sum_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      recip_start = 1'b0;
      emit_start  = 1'b0;
      unique case (state_ff)
         S_ACC: begin
            if (accept) begin
               if (room) begin
                  sum_in   = sum_ff + SUM_WIDTH'(ax * ax);
                  count_in = count_ff + COUNT_WIDTH'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_element) state_in = S_LAUNCH;
            end
         end
         S_LAUNCH: begin
            recip_start = 1'b1;
            state_in    = S_RECIP;
         end
         S_RECIP: begin
            if (root.done) begin
               emit_start = 1'b1;
               state_in   = S_EMIT;
            end
         end
         S_EMIT: begin
            if (row_done) begin
               state_in = S_ACC;
               sum_in   = '0;
               count_in = '0;
               ovf_in   = 1'b0;
            end
         end
         default: state_in = S_ACC;
      endcase
   end

   assign ectl = '{start: emit_start, count: count_ff, overflow: ovf_ff};

   rmsn_store #(.ROW_MAX(ROW_MAX), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rmsn_recip u_recip (
      .clock (clock),
      .reset (reset),
      .start (recip_start),
      .sum   (sum_ff),
      .count (count_ff),
      .eps   (eps_ff),
      .root  (root)
   );

   rmsn_emit #(.ROW_MAX(ROW_MAX), .AW(AW)) u_emit (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ectl),
      .root      (root),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `RMSN_ASSERT(a_no_write_busy, clock, reset, busy |-> !wr_en, "store written while busy")
   `RMSN_ASSERT(a_rsp_in_emit, clock, reset, rsp_valid |-> (state_ff == S_EMIT), "beat outside emit")
   `RMSN_ASSERT(a_idle_after_row, clock, reset, row_done |=> !busy, "busy after final beat")
   `RMSN_ASSERT(a_launch_once, clock, reset, (state_ff == S_LAUNCH) |=> (state_ff == S_RECIP), "launch stuck")
endmodule
`default_nettype wire
